// ===== src/source_token_lexer_unit_defines.svh =====
// Assertion macros shared by the lexer sources.
`ifndef SOURCE_TOKEN_LEXER_UNIT_DEFINES_SVH
`define SOURCE_TOKEN_LEXER_UNIT_DEFINES_SVH

// Implication check on the rising clock, held off during reset.
`define STL_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication check.
`define STL_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/stl_pkg.sv =====
`timescale 1ns / 1ps
package stl_pkg;
    localparam int MAX_KEYWORD_LEN_DEF = 6;
    localparam int OFFSET_BITS_DEF     = 24;
    localparam int LENGTH_BITS_DEF     = 16;
    localparam int LINE_BITS_DEF       = 16;

    localparam logic [5:0] K_EOF    = 6'd0;
    localparam logic [5:0] K_DOT    = 6'd7;
    localparam logic [5:0] K_NUMBER = 6'd23;
    localparam logic [5:0] K_STRING = 6'd24;
    localparam logic [5:0] K_IDENT  = 6'd41;
    localparam logic [5:0] K_ERROR  = 6'd42;

    localparam logic [2:0] M_IDLE     = 3'd0;
    localparam logic [2:0] M_COMMENT  = 3'd1;
    localparam logic [2:0] M_IDENT    = 3'd2;
    localparam logic [2:0] M_NUM_INT  = 3'd3;
    localparam logic [2:0] M_NUM_DOT  = 3'd4;
    localparam logic [2:0] M_NUM_FRAC = 3'd5;
    localparam logic [2:0] M_STRING   = 3'd6;
    localparam logic [2:0] M_OP       = 3'd7;

    localparam logic E_UNEXPECTED   = 1'b0;
    localparam logic E_UNTERMINATED = 1'b1;

    function automatic logic is_letter(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a);
    endfunction

    function automatic logic is_decimal(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    // Single-byte tokens: kind, or 0 when the byte is none of them.
    function automatic logic [5:0] single_kind(input logic [7:0] c);
        logic [5:0] k;
        k = 6'd0;
        unique case (c)
            8'h28: k = 6'd1;  8'h29: k = 6'd2;  8'h7b: k = 6'd3;  8'h7d: k = 6'd4;
            8'h5b: k = 6'd5;  8'h5d: k = 6'd6;  8'h2e: k = 6'd7;  8'h2d: k = 6'd8;
            8'h2b: k = 6'd9;  8'h2f: k = 6'd10; 8'h2a: k = 6'd11; 8'h2c: k = 6'd12;
            8'h3b: k = 6'd13; 8'h3a: k = 6'd14;
            default: k = 6'd0;
        endcase
        return k;
    endfunction

    // Keyword lookup on up to six prefix bytes, packed first byte lowest.
    function automatic logic [5:0] kw_kind(input logic [47:0] p, input logic [2:0] n);
        logic [5:0] k;
        k = K_IDENT;
        unique case (n)
            3'd2: begin
                if (p[15:0] == 16'h6e66) k = 6'd31;        // fn
                else if (p[15:0] == 16'h6669) k = 6'd32;   // if
                else if (p[15:0] == 16'h726f) k = 6'd35;   // or
            end
            3'd3: begin
                if (p[23:0] == 24'h646e61) k = 6'd25;      // and
                else if (p[23:0] == 24'h726f66) k = 6'd30; // for
                else if (p[23:0] == 24'h676f6c) k = 6'd33; // log
                else if (p[23:0] == 24'h727473) k = 6'd36; // str
            end
            3'd4: begin
                if (p[31:0] == 32'h6c6f6f62) k = 6'd26;      // bool
                else if (p[31:0] == 32'h74706d63) k = 6'd27; // cmpt
                else if (p[31:0] == 32'h65736c65) k = 6'd28; // else
                else if (p[31:0] == 32'h65757274) k = 6'd38; // true
                else if (p[31:0] == 32'h65707974) k = 6'd39; // type
            end
            3'd5: begin
                if (p[39:0] == 40'h65736c6166) k = 6'd29;      // false
                else if (p[39:0] == 40'h656c696877) k = 6'd40; // while
            end
            3'd6: begin
                if (p == 48'h7265626d756e) k = 6'd34;      // number
                else if (p == 48'h6e7275746572) k = 6'd37; // return
            end
            default: k = K_IDENT;
        endcase
        return k;
    endfunction
endpackage

// ===== src/stl_scan.sv =====
`timescale 1ns / 1ps
`include "source_token_lexer_unit_defines.svh"
module stl_scan import stl_pkg::*; #(
    parameter int MAX_KEYWORD_LEN = MAX_KEYWORD_LEN_DEF,
    parameter int OFFSET_BITS     = OFFSET_BITS_DEF,
    parameter int LENGTH_BITS     = LENGTH_BITS_DEF,
    parameter int LINE_BITS       = LINE_BITS_DEF,
    parameter int TOK_BITS        = 6 + OFFSET_BITS + LENGTH_BITS + LINE_BITS + 1
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  logic [7:0]            i_byte,
    input  logic                  i_end,
    output logic [2:0]            o_count,
    output logic [TOK_BITS-1:0]   o_tok0,
    output logic [TOK_BITS-1:0]   o_tok1,
    output logic [TOK_BITS-1:0]   o_tok2
);
    localparam int KB = $clog2(MAX_KEYWORD_LEN);
    localparam logic [OFFSET_BITS-1:0] OFF_MAX = '1;
    localparam logic [LENGTH_BITS-1:0] LEN_MAX = '1;
    localparam logic [LINE_BITS-1:0]   LIN_MAX = '1;

    logic [2:0]             r_mode, n_mode;
    logic [OFFSET_BITS-1:0] r_start, n_start, r_off, n_off;
    logic [LENGTH_BITS-1:0] r_cnt, n_cnt;
    logic [LINE_BITS-1:0]   r_line, n_line;
    logic [1:0]             r_pop, n_pop;
    logic [7:0]             r_pre [MAX_KEYWORD_LEN];
    logic                   pre_we;
    logic [KB-1:0]          pre_idx;

    logic [TOK_BITS-1:0] t [3];
    logic [2:0] cnt;
    logic [47:0] pfx;
    logic [5:0] idk;

    function automatic logic [LENGTH_BITS-1:0] li(input logic [LENGTH_BITS-1:0] v);
        return (v == LEN_MAX) ? v : v + 1'b1;
    endfunction

    always_comb begin
        pfx = '0;
        for (int i = 0; i < 6; i++) pfx[i*8 +: 8] = r_pre[i];
        idk = (r_cnt > LENGTH_BITS'(MAX_KEYWORD_LEN) || r_cnt > LENGTH_BITS'(6) ||
               r_cnt == '0) ? K_IDENT : kw_kind(pfx, r_cnt[2:0]);
    end

    always_comb begin
        logic rescan;
        logic [5:0] sk;
        logic [OFFSET_BITS-1:0] dot_off;
        n_mode = r_mode; n_start = r_start; n_cnt = r_cnt; n_off = r_off;
        n_line = r_line; n_pop = r_pop; pre_we = 1'b0; pre_idx = '0;
        cnt = 3'd0; rescan = 1'b0;
        sk = single_kind(i_byte);
        dot_off = (r_off != '0) ? r_off - 1'b1 : '0;
        for (int i = 0; i < 3; i++) begin
            t[i] = '0;
        end
        if (i_end) begin
            unique case (r_mode)
                M_IDENT: begin
                    t[0] = {idk, r_start, r_cnt, r_line, 1'b0}; cnt = 3'd1;
                end
                M_NUM_INT, M_NUM_FRAC: begin
                    t[0] = {K_NUMBER, r_start, r_cnt, r_line, 1'b0}; cnt = 3'd1;
                end
                M_NUM_DOT: begin
                    t[0] = {K_NUMBER, r_start, r_cnt, r_line, 1'b0};
                    t[1] = {K_DOT, dot_off, LENGTH_BITS'(1), r_line, 1'b0}; cnt = 3'd2;
                end
                M_STRING: begin
                    t[0] = {K_ERROR, r_start, r_cnt, r_line, E_UNTERMINATED}; cnt = 3'd1;
                end
                M_OP: begin
                    t[0] = {6'(16 + 2 * r_pop), r_start, LENGTH_BITS'(1), r_line, 1'b0};
                    cnt = 3'd1;
                end
                default: cnt = 3'd0;
            endcase
            t[cnt[1:0]] = {K_EOF, r_off, LENGTH_BITS'(0), r_line, 1'b0};
            cnt = cnt + 3'd1;
            n_mode = M_IDLE; n_off = '0; n_line = LINE_BITS'(1); n_cnt = '0; n_pop = '0;
        end else begin
            rescan = 1'b1;
            unique case (r_mode)
                M_COMMENT: rescan = (i_byte == 8'h0a);
                M_IDENT: if (is_letter(i_byte) || is_decimal(i_byte)) begin
                    rescan = 1'b0;
                    if (r_cnt < LENGTH_BITS'(MAX_KEYWORD_LEN)) begin
                        pre_we = 1'b1; pre_idx = r_cnt[KB-1:0];
                    end
                    n_cnt = li(r_cnt);
                end else begin
                    t[0] = {idk, r_start, r_cnt, r_line, 1'b0}; cnt = 3'd1;
                end
                M_NUM_INT: if (is_decimal(i_byte)) begin
                    rescan = 1'b0; n_cnt = li(r_cnt);
                end else if (i_byte == 8'h2e) begin
                    rescan = 1'b0; n_mode = M_NUM_DOT;
                end else begin
                    t[0] = {K_NUMBER, r_start, r_cnt, r_line, 1'b0}; cnt = 3'd1;
                end
                M_NUM_DOT: if (is_decimal(i_byte)) begin
                    rescan = 1'b0; n_cnt = li(li(r_cnt)); n_mode = M_NUM_FRAC;
                end else begin
                    t[0] = {K_NUMBER, r_start, r_cnt, r_line, 1'b0};
                    t[1] = {K_DOT, dot_off, LENGTH_BITS'(1), r_line, 1'b0}; cnt = 3'd2;
                end
                M_NUM_FRAC: if (is_decimal(i_byte)) begin
                    rescan = 1'b0; n_cnt = li(r_cnt);
                end else begin
                    t[0] = {K_NUMBER, r_start, r_cnt, r_line, 1'b0}; cnt = 3'd1;
                end
                M_STRING: if (i_byte == 8'h22) begin
                    rescan = 1'b0; n_cnt = li(r_cnt); n_mode = M_IDLE;
                    t[0] = {K_STRING, r_start, li(r_cnt), r_line, 1'b0}; cnt = 3'd1;
                end else if (i_byte == 8'h0a) begin
                    t[0] = {K_ERROR, r_start, r_cnt, r_line, E_UNTERMINATED}; cnt = 3'd1;
                end else begin
                    rescan = 1'b0; n_cnt = li(r_cnt);
                end
                M_OP: if (i_byte == 8'h3d) begin
                    rescan = 1'b0; n_mode = M_IDLE;
                    t[0] = {6'(15 + 2 * r_pop), r_start, LENGTH_BITS'(2), r_line, 1'b0};
                    cnt = 3'd1;
                end else begin
                    t[0] = {6'(16 + 2 * r_pop), r_start, LENGTH_BITS'(1), r_line, 1'b0};
                    cnt = 3'd1;
                end
                default: rescan = 1'b1;
            endcase
            if (rescan) begin
                n_mode = M_IDLE;
                priority if (i_byte == 8'h20 || i_byte == 8'h09 || i_byte == 8'h0d) begin
                end else if (i_byte == 8'h0a) begin
                    n_line = (r_line == LIN_MAX) ? r_line : r_line + 1'b1;
                end else if (i_byte == 8'h23) begin
                    n_mode = M_COMMENT;
                end else begin
                    n_start = r_off; n_cnt = LENGTH_BITS'(1);
                    priority if (is_letter(i_byte)) begin
                        n_mode = M_IDENT; pre_we = 1'b1; pre_idx = '0;
                    end else if (is_decimal(i_byte)) begin
                        n_mode = M_NUM_INT;
                    end else if (i_byte == 8'h22) begin
                        n_mode = M_STRING;
                    end else if (sk != 6'd0) begin
                        t[cnt[1:0]] = {sk, r_off, LENGTH_BITS'(1), r_line, 1'b0};
                        cnt = cnt + 3'd1;
                    end else if (i_byte == 8'h21 || i_byte == 8'h3d ||
                                 i_byte == 8'h3c || i_byte == 8'h3e) begin
                        n_mode = M_OP;
                        n_pop = (i_byte == 8'h21) ? 2'd0 : (i_byte == 8'h3d) ? 2'd1 :
                                (i_byte == 8'h3c) ? 2'd2 : 2'd3;
                    end else begin
                        t[cnt[1:0]] = {K_ERROR, r_off, LENGTH_BITS'(1), r_line, E_UNEXPECTED};
                        cnt = cnt + 3'd1;
                    end
                end
            end
            n_off = (r_off == OFF_MAX) ? r_off : r_off + 1'b1;
        end
    end

    assign o_count = i_valid ? cnt : 3'd0;
    assign o_tok0 = t[0];
    assign o_tok1 = t[1];
    assign o_tok2 = t[2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= M_IDLE; r_start <= '0; r_cnt <= '0; r_off <= '0;
            r_line <= LINE_BITS'(1); r_pop <= '0;
        end else if (i_valid) begin
            r_mode <= n_mode; r_start <= n_start; r_cnt <= n_cnt; r_off <= n_off;
            r_line <= n_line; r_pop <= n_pop;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && pre_we) r_pre[pre_idx] <= i_byte;
    end

    `STL_ASSERT_IMP(a_end_emits, i_clk, i_rst_n, i_valid && i_end, o_count != 3'd0,
        "end mark must emit Eof")
    `STL_ASSERT_NXT(a_end_idle, i_clk, i_rst_n, i_valid && i_end, r_mode == M_IDLE,
        "mode not idle after end")
    `STL_ASSERT_IMP(a_cnt_max, i_clk, i_rst_n, 1'b1, o_count <= 3'd3,
        "too many tokens in one step")
endmodule

// ===== src/stl_queue.sv =====
`timescale 1ns / 1ps
`include "source_token_lexer_unit_defines.svh"
module stl_queue #(
    parameter int W     = 64,
    parameter int DEPTH = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic [2:0]   i_count,
    input  logic [W-1:0] i_tok0,
    input  logic [W-1:0] i_tok1,
    input  logic [W-1:0] i_tok2,
    output logic         o_room,
    output logic         o_valid,
    output logic [W-1:0] o_data,
    output logic         o_last,
    input  logic         i_ready
);
    localparam int AB = $clog2(DEPTH);
    logic [W:0]   r_mem [DEPTH];
    logic [AB-1:0] r_wp, r_rp;
    logic [AB:0]   r_fill;
    logic          pop;

    assign o_valid = r_fill != '0;
    assign pop     = o_valid && i_ready;
    assign {o_last, o_data} = r_mem[r_rp];
    // Keep room for a worst-case burst of three.
    assign o_room  = r_fill <= (AB+1)'(DEPTH - 3);

    always_ff @(posedge i_clk) begin
        if (i_count > 3'd0) r_mem[r_wp] <= {i_count == 3'd1, i_tok0};
        if (i_count > 3'd1) r_mem[AB'(r_wp + 1'b1)] <= {i_count == 3'd2, i_tok1};
        if (i_count > 3'd2) r_mem[AB'(r_wp + 2'd2)] <= {1'b1, i_tok2};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_fill <= '0;
        end else begin
            r_wp   <= AB'(r_wp + i_count);
            r_rp   <= r_rp + AB'(pop);
            r_fill <= r_fill + (AB+1)'(i_count) - (AB+1)'(pop);
        end
    end

    `STL_ASSERT_IMP(a_no_over, i_clk, i_rst_n, i_count != 3'd0,
        r_fill + (AB+1)'(i_count) <= (AB+1)'(DEPTH), "queue overflow")
    `STL_ASSERT_NXT(a_hold, i_clk, i_rst_n, o_valid && !i_ready && i_count == 3'd0,
        o_valid, "queued beat lost")
    `STL_ASSERT_IMP(a_fill_rng, i_clk, i_rst_n, 1'b1, r_fill <= (AB+1)'(DEPTH),
        "fill count out of range")
endmodule

// ===== src/source_token_lexer_unit.sv =====
`timescale 1ns / 1ps
// Channel | Dir | tdata fields (low bit up)                         | tuser/tlast
// s_axis  | in  | byte_in[7:0]                                       | tuser end_of_input
// m_axis  | out | kind, start_offset, token_length, line, error_code | tlast last_of_run
// One byte is scanned per cycle while s_axis_tready is high, in a single registered pass; a step yields 0..3 tokens.
// Tokens go into an 8-deep output queue; s_axis_tready drops while fewer than 3 slots are
// free, so a sustained rate of one byte per cycle holds while m_axis drains.
// Reset (i_rst_n low, synchronous) empties the queue, sets line count to 1 and offset to 0.
// m_axis stalls only fill the queue; the scanner keeps state until the next accepted beat.
module source_token_lexer_unit import stl_pkg::*; #(
    parameter int MAX_KEYWORD_LEN = MAX_KEYWORD_LEN_DEF,
    parameter int OFFSET_BITS     = OFFSET_BITS_DEF,
    parameter int LENGTH_BITS     = LENGTH_BITS_DEF,
    parameter int LINE_BITS       = LINE_BITS_DEF,
    parameter int DATA_BITS       = 6 + OFFSET_BITS + LENGTH_BITS + LINE_BITS + 1,
    parameter int TDATA_W         = ((DATA_BITS + 7) / 8) * 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [7:0]         s_axis_tdata,   // byte_in[7:0]
    input  logic               s_axis_tuser,   // end_of_input
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    // token_kind, start_offset, token_length, line_number, error_code, zero pad
    output logic [TDATA_W-1:0] m_axis_tdata,
    output logic               m_axis_tlast    // last_of_run
);
    localparam int TW = 6 + OFFSET_BITS + LENGTH_BITS + LINE_BITS + 1;

    logic          acc;
    logic [2:0]    cnt;
    logic [TW-1:0] t0, t1, t2, q;
    logic          room;

    // Accept a beat whenever the queue can absorb its worst-case burst.
    assign s_axis_tready = room;
    assign acc = s_axis_tvalid && room;

    stl_scan #(
        .MAX_KEYWORD_LEN(MAX_KEYWORD_LEN), .OFFSET_BITS(OFFSET_BITS),
        .LENGTH_BITS(LENGTH_BITS), .LINE_BITS(LINE_BITS), .TOK_BITS(TW)
    ) u_scan (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(acc), .i_byte(s_axis_tdata),
        .i_end(s_axis_tuser), .o_count(cnt), .o_tok0(t0), .o_tok1(t1), .o_tok2(t2)
    );

    stl_queue #(.W(TW), .DEPTH(8)) u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_count(cnt), .i_tok0(t0), .i_tok1(t1),
        .i_tok2(t2), .o_room(room), .o_valid(m_axis_tvalid), .o_data(q),
        .o_last(m_axis_tlast), .i_ready(m_axis_tready)
    );

    // Token packs kind in the top bits; reorder so kind lands lowest on the bus.
    always_comb begin
        m_axis_tdata = '0;
        m_axis_tdata[5:0] = q[TW-1 -: 6];
        m_axis_tdata[6 +: OFFSET_BITS] = q[LENGTH_BITS+LINE_BITS+1 +: OFFSET_BITS];
        m_axis_tdata[6+OFFSET_BITS +: LENGTH_BITS] = q[LINE_BITS+1 +: LENGTH_BITS];
        m_axis_tdata[6+OFFSET_BITS+LENGTH_BITS +: LINE_BITS] = q[1 +: LINE_BITS];
        m_axis_tdata[TW-1] = q[0];
    end
endmodule
